// ----- rtl/pidaw_pkg.sv -----
// ----------------------------------------------------------------------------
// pidaw_pkg
// shared types and constants of the pid controller with integral clamp
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int MD_W     = 64;
    localparam int MD_CNT_W = $clog2(2 * MD_W);

    typedef struct packed {
        logic [MD_W-1:0] a;
        logic [MD_W-1:0] b;
        logic [MD_W-1:0] d;
        logic [MD_W-1:0] cap;
    } t_md_req;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DER_GO,
        S_DER_WAIT,
        S_ACC,
        S_INT_GO,
        S_INT_WAIT,
        S_RST_GO,
        S_RST_WAIT,
        S_MUL,
        S_SUM,
        S_OUT
    } t_state;

    typedef logic [1:0] t_status;
    localparam t_status ST_NORMAL  = 2'd0;
    localparam t_status ST_PRIME   = 2'd1;
    localparam t_status ST_TIMEOUT = 2'd2;
    localparam t_status ST_RESTART = 2'd3;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PROP_GAIN    = 3'd0;
    localparam t_cfg_idx CFG_INT_TIME     = 3'd1;
    localparam t_cfg_idx CFG_DER_TIME     = 3'd2;
    localparam t_cfg_idx CFG_INT_LIMIT    = 3'd3;
    localparam t_cfg_idx CFG_FEEDFORWARD  = 3'd4;
    localparam t_cfg_idx CFG_DER_ON_FB    = 3'd5;
    localparam t_cfg_idx CFG_TIMEOUT      = 3'd6;
    localparam t_cfg_idx CFG_MIN_DT       = 3'd7;

endpackage

// ----- rtl/pid_antiwindup_controller.sv -----
// ----------------------------------------------------------------------------
// pid_antiwindup_controller
// fixed-point pid controller with clamped integral and timeout handling
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_stall   time, setpoint, feedback, restart
// out      output     o_out_valid / i_out_stall drive, status
// cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// restart, priming and timeout items go from S_CHECK straight to S_OUT
// a normal item's duration is set by the shared serial multiply-divide unit
// (up to three passes of shift-add plus 128 divide steps)
// one item at a time; o_in_stall is high from acceptance until the result
// is loaded; a stalled output holds the block in its last state
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module pid_antiwindup_controller import pidaw_pkg::*; #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [31:0]                  i_sample_time_us,
    input  logic signed [DATA_WIDTH-1:0] i_setpoint,
    input  logic signed [DATA_WIDTH-1:0] i_feedback,
    input  logic                         i_restart,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [15:0]           o_drive,
    output logic [1:0]                   o_status,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_idx,
    input  logic [31:0]                  i_cfg_data
);

    localparam int DW  = DATA_WIDTH;
    localparam int EW  = DW + 1;
    localparam int DLW = DW + 2;
    localparam int IW  = EW + 33;
    localparam int SW  = ((ACC_WIDTH > IW) ? ACC_WIDTH : IW) + 2;
    localparam int PW  = ((EW > 34) ? EW : 34) + 1;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX_V = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN_V = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    // configuration
    logic signed [31:0]     r_kp;
    logic [31:0]            r_ti;
    logic [31:0]            r_td;
    logic [15:0]            r_limit;
    logic signed [15:0]     r_ff;
    logic                   r_dof;
    logic [23:0]            r_timeout;
    logic [23:0]            r_min_dt;

    // controller state
    logic                   r_primed;
    logic [31:0]            r_last_time;
    logic signed [DW-1:0]   r_last_fb;
    logic signed [EW-1:0]   r_last_err;
    logic signed [ACC_WIDTH-1:0] r_acc;

    // item and working registers
    t_state                 r_state;
    t_state                 n_state;
    logic [31:0]            r_t;
    logic signed [DW-1:0]   r_sp;
    logic signed [DW-1:0]   r_fb;
    logic                   r_rst_req;
    logic [31:0]            r_dt;
    logic signed [EW-1:0]   r_ek;
    logic signed [DLW-1:0]  r_delta;
    logic signed [32:0]     r_p;
    logic signed [IW-1:0]   r_inc;
    logic signed [17:0]     r_integ;
    logic signed [64:0]     r_prod;
    logic signed [15:0]     r_drive;
    t_status                r_status;

    logic                   r_out_valid;
    logic signed [15:0]     r_out_drive;
    t_status                r_out_status;

    logic                   md_start;
    t_md_req                md_req;
    logic                   md_done;
    logic [MD_W-1:0]        md_q;

    // datapath helpers
    logic [31:0]            gap;
    logic                   gap_over;
    logic [23:0]            mind;
    logic [31:0]            dt_c;
    logic signed [EW-1:0]   ek_c;
    logic signed [DLW-1:0]  delta_c;
    logic [DLW-1:0]         mag_delta;
    logic [31:0]            m32;
    logic signed [33:0]     d_s;
    logic signed [PW-1:0]   p_full;
    logic signed [SW-1:0]   acc_sum;
    logic [ACC_WIDTH-1:0]   mag_acc;
    logic [31:0]            mag_kp;
    logic [MD_W-1:0]        ti_1e6;
    logic [MD_W-1:0]        td_k;
    logic                   clamped;
    logic [16:0]            m_c;
    logic [ACC_WIDTH-1:0]   rq;
    logic signed [17:0]     if_sum;
    logic signed [66:0]     tau_f;
    logic signed [66:0]     tau_q;
    logic                   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        gap       = r_t - r_last_time;
        gap_over  = $signed({gap[31], gap}) > $signed({9'd0, r_timeout});
        mind      = (r_min_dt == '0) ? 24'd1 : r_min_dt;
        dt_c      = ($signed(gap) < $signed({8'd0, mind})) ? {8'd0, mind} : gap;
        ek_c      = EW'(r_sp) - EW'(r_fb);
        delta_c   = r_dof ? (DLW'(r_last_fb) - DLW'(r_fb))
                          : (DLW'(ek_c) - DLW'(r_last_err));
        mag_delta = r_delta[DLW-1] ? DLW'(-r_delta) : DLW'(r_delta);
        m32       = md_q[31:0];
        d_s       = r_delta[DLW-1] ? -$signed({2'b00, m32}) : $signed({2'b00, m32});
        p_full    = PW'(r_ek) + PW'(d_s);
        acc_sum   = SW'(r_acc) + SW'(r_inc);
        mag_acc   = r_acc[ACC_WIDTH-1] ? ACC_WIDTH'(-r_acc) : ACC_WIDTH'(r_acc);
        mag_kp    = r_kp[31] ? 32'(-r_kp) : 32'(r_kp);
        ti_1e6    = {{(MD_W-32){1'b0}}, r_ti} * MD_W'(1000000);
        td_k      = {{(MD_W-32){1'b0}}, r_td} * MD_W'(15625);
        clamped   = md_q > MD_W'(r_limit);
        m_c       = clamped ? {1'b0, r_limit} : md_q[16:0];
        rq        = md_q[ACC_WIDTH-1:0];
        if_sum    = r_integ + 18'(r_ff);
        tau_f     = 67'(r_prod) + (67'(if_sum) <<< 13);
        tau_q     = (tau_f < 0) ? ((tau_f + 67'sd8191) >>> 13) : (tau_f >>> 13);
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        md_start = 1'b0;
        md_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_rst_req || !r_primed || gap_over) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DER_GO;
                end
            end
            S_DER_GO: begin
                md_start   = 1'b1;
                md_req.a   = MD_W'(mag_delta);
                md_req.b   = td_k;
                md_req.d   = {{(MD_W-42){1'b0}}, r_dt, 10'd0};
                md_req.cap = MD_W'(64'h8000_0000);
                n_state    = S_DER_WAIT;
            end
            S_DER_WAIT: begin
                if (md_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = (r_ti != '0) ? S_INT_GO : S_MUL;
            end
            S_INT_GO: begin
                md_start   = 1'b1;
                md_req.a   = MD_W'(mag_acc);
                md_req.b   = MD_W'({mag_kp, 3'b000});
                md_req.d   = ti_1e6;
                md_req.cap = MD_W'(r_limit) + MD_W'(1);
                n_state    = S_INT_WAIT;
            end
            S_INT_WAIT: begin
                if (md_done) begin
                    if (r_kp[31] || r_kp == '0 || !clamped) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_RST_GO;
                    end
                end
            end
            S_RST_GO: begin
                md_start   = 1'b1;
                md_req.a   = ti_1e6;
                md_req.b   = MD_W'(r_limit);
                md_req.d   = MD_W'({r_kp, 3'b000});
                md_req.cap = MD_W'(ACC_MAX_V);
                n_state    = S_RST_WAIT;
            end
            S_RST_WAIT: begin
                if (md_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed    <= 1'b0;
            r_last_time <= '0;
            r_last_fb   <= '0;
            r_last_err  <= '0;
            r_acc       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_t       <= i_sample_time_us;
                        r_sp      <= i_setpoint;
                        r_fb      <= i_feedback;
                        r_rst_req <= i_restart;
                    end
                end
                S_CHECK: begin
                    r_drive <= '0;
                    if (r_rst_req) begin
                        r_acc    <= '0;
                        r_primed <= 1'b0;
                        r_status <= ST_RESTART;
                    end else if (!r_primed) begin
                        r_last_time <= r_t;
                        r_last_fb   <= r_fb;
                        r_last_err  <= ek_c;
                        r_primed    <= 1'b1;
                        r_status    <= ST_PRIME;
                    end else if (gap_over) begin
                        r_acc    <= '0;
                        r_primed <= 1'b0;
                        r_status <= ST_TIMEOUT;
                    end else begin
                        r_last_time <= r_t;
                        r_dt        <= dt_c;
                        r_ek        <= ek_c;
                        r_delta     <= delta_c;
                        r_status    <= ST_NORMAL;
                    end
                end
                S_DER_GO: begin
                    r_inc <= IW'(r_ek) * IW'($signed({1'b0, r_dt}));
                end
                S_DER_WAIT: begin
                    if (md_done) begin
                        if (p_full > PW'(64'sh8000_0000)) begin
                            r_p <= 33'sh0_8000_0000;
                        end else if (p_full < -PW'(64'sh8000_0000)) begin
                            r_p <= -33'sh0_8000_0000;
                        end else begin
                            r_p <= p_full[32:0];
                        end
                    end
                end
                S_ACC: begin
                    r_integ <= '0;
                    if (acc_sum > SW'($signed(ACC_MAX_V))) begin
                        r_acc <= ACC_MAX_V;
                    end else if (acc_sum < SW'($signed(ACC_MIN_V))) begin
                        r_acc <= ACC_MIN_V;
                    end else begin
                        r_acc <= acc_sum[ACC_WIDTH-1:0];
                    end
                end
                S_INT_WAIT: begin
                    if (md_done) begin
                        r_integ <= (r_acc[ACC_WIDTH-1] != r_kp[31])
                                   ? -$signed({1'b0, m_c}) : $signed({1'b0, m_c});
                        if (r_kp[31] || r_kp == '0) begin
                            r_acc <= '0;
                        end
                    end
                end
                S_RST_WAIT: begin
                    if (md_done) begin
                        r_acc <= r_acc[ACC_WIDTH-1] ? -rq : rq;
                    end
                end
                S_MUL: begin
                    r_prod <= 65'(r_kp) * 65'(r_p);
                end
                S_SUM: begin
                    if (tau_q > 67'sd32767) begin
                        r_drive <= 16'sd32767;
                    end else if (tau_q < -67'sd32767) begin
                        r_drive <= -16'sd32767;
                    end else begin
                        r_drive <= tau_q[15:0];
                    end
                    r_last_fb  <= r_fb;
                    r_last_err <= r_ek;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid  <= 1'b1;
            r_out_drive  <= r_drive;
            r_out_status <= r_status;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= '0;
            r_ti      <= '0;
            r_td      <= '0;
            r_limit   <= '0;
            r_ff      <= '0;
            r_dof     <= 1'b1;
            r_timeout <= 24'd200000;
            r_min_dt  <= 24'd10000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROP_GAIN:   r_kp      <= i_cfg_data;
                CFG_INT_TIME:    r_ti      <= i_cfg_data;
                CFG_DER_TIME:    r_td      <= i_cfg_data;
                CFG_INT_LIMIT:   r_limit   <= i_cfg_data[15:0];
                CFG_FEEDFORWARD: r_ff      <= i_cfg_data[15:0];
                CFG_DER_ON_FB:   r_dof     <= i_cfg_data[0];
                CFG_TIMEOUT:     r_timeout <= i_cfg_data[23:0];
                CFG_MIN_DT:      r_min_dt  <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    pidaw_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_req   (md_req),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out_drive;
    assign o_status    = r_out_status;

`ifndef SYNTHESIS
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_drive != 16'sh8000)
        else $error("drive outside saturation range");

    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_NORMAL) |-> o_drive == 16'sd0)
        else $error("nonzero drive on special item");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("ready again right after accepting an item");

    a_md_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_start |=> !md_done)
        else $error("muldiv done right after start");
`endif

endmodule

// ----- rtl/pidaw_muldiv.sv -----
// ----------------------------------------------------------------------------
// pidaw_muldiv
// shared serial unit: min(floor(a*b/d), cap), shift-add then restoring divide
// ----------------------------------------------------------------------------
module pidaw_muldiv import pidaw_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  t_md_req         i_req,
    output logic            o_done,
    output logic [MD_W-1:0] o_q
);

    t_md_phase             r_phase;
    logic [2*MD_W-1:0]     r_mcand;
    logic [MD_W-1:0]       r_mplier;
    logic [2*MD_W-1:0]     r_prod;
    logic [MD_W-1:0]       r_d;
    logic [MD_W-1:0]       r_cap;
    logic [MD_W-1:0]       r_rem;
    logic [MD_W-1:0]       r_q;
    logic                  r_over;
    logic [MD_CNT_W-1:0]   r_cnt;
    logic                  r_done;
    logic [MD_W-1:0]       r_res;

    logic [MD_W:0]         rem_sh;
    logic                  ge;
    logic [MD_W:0]         rem_sub;
    logic [MD_W-1:0]       n_rem;
    logic [MD_W-1:0]       n_q;
    logic                  n_over;

    always_comb begin
        rem_sh  = {r_rem, r_prod[2*MD_W-1]};
        ge      = rem_sh >= {1'b0, r_d};
        rem_sub = rem_sh - {1'b0, r_d};
        n_rem   = ge ? rem_sub[MD_W-1:0] : rem_sh[MD_W-1:0];
        n_q     = {r_q[MD_W-2:0], ge};
        n_over  = r_over | r_q[MD_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                MD_IDLE: begin
                    if (i_start) begin
                        r_mcand  <= {{MD_W{1'b0}}, i_req.a};
                        r_mplier <= i_req.b;
                        r_prod   <= '0;
                        r_d      <= i_req.d;
                        r_cap    <= i_req.cap;
                        r_phase  <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    if (r_mplier == '0) begin
                        r_phase <= MD_DIV;
                        r_cnt   <= '1;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_over  <= 1'b0;
                    end else begin
                        if (r_mplier[0]) begin
                            r_prod <= r_prod + r_mcand;
                        end
                        r_mcand  <= {r_mcand[2*MD_W-2:0], 1'b0};
                        r_mplier <= {1'b0, r_mplier[MD_W-1:1]};
                    end
                end
                MD_DIV: begin
                    r_prod <= {r_prod[2*MD_W-2:0], 1'b0};
                    r_rem  <= n_rem;
                    r_q    <= n_q;
                    r_over <= n_over;
                    if (r_cnt == '0) begin
                        r_res   <= (n_over || n_q > r_cap) ? r_cap : n_q;
                        r_done  <= 1'b1;
                        r_phase <= MD_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_phase <= MD_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the pid controller with integral clamp: a driver
// feeds timestamped samples from a queue, a software copy of the controller
// predicts drive and status, and a monitor compares every output item
// ----------------------------------------------------------------------------
module testbench;
    import pidaw_pkg::*;

    localparam longint ACC_MAX = (longint'(1) << 47) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint P_CAP   = longint'(1) << 31;
    localparam int     LIMIT   = 4000000;

    typedef struct {
        logic [31:0]        t;
        logic signed [15:0] sp;
        logic signed [15:0] fb;
        logic               rst;
    } sample_t;

    typedef struct {
        logic signed [15:0] drive;
        t_status            status;
    } ctl_out_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [31:0]        i_sample_time_us;
    logic signed [15:0] i_setpoint;
    logic signed [15:0] i_feedback;
    logic               i_restart;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_drive;
    logic [1:0]         o_status;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;

    pid_antiwindup_controller uut (.*);

    // controller copy: configuration
    longint      kp, ff;
    logic [63:0] ti, td, ilim, tmo, mindt;
    logic        dof;
    // controller copy: state
    logic        primed;
    logic [31:0] last_t;
    longint      last_fb, last_err, acc;

    sample_t  samples_q[$];
    ctl_out_t drive_expect_q[$];
    sample_t  cur;
    int       err_count = 0;
    int       cycles = 0;
    logic     gaps_on;
    int       hold_req = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    logic [31:0] next_t;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample_time_us = '0;
        i_setpoint = '0;
        i_feedback = '0;
        i_restart = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        gaps_on = 1'b1;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [63:0] mag(longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // floor(a*b/d) capped, full-width product
    function automatic logic [63:0] mul_div_cap(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] d, logic [63:0] cap);
        logic [127:0] prod;
        logic [127:0] q;
        if (d == 0) return cap;
        prod = {64'b0, a} * {64'b0, b};
        q = prod / {64'b0, d};
        return (q > {64'b0, cap}) ? cap : q[63:0];
    endfunction

    function automatic ctl_out_t pid_predict(sample_t s);
        ctl_out_t    r;
        int          g32;
        longint      gap, dt, md, sp, fb, ek, delta, d, p, inc, integ, tau;
        logic [63:0] m, rr;
        logic        clamped;
        r.drive = '0;
        sp = s.sp;
        fb = s.fb;
        integ = 0;
        if (s.rst) begin
            acc = 0;
            primed = 1'b0;
            r.status = ST_RESTART;
            return r;
        end
        if (!primed) begin
            last_t = s.t;
            last_fb = fb;
            last_err = sp - fb;
            primed = 1'b1;
            r.status = ST_PRIME;
            return r;
        end
        g32 = int'(s.t - last_t);
        gap = g32;
        if (gap > longint'(tmo)) begin
            acc = 0;
            primed = 1'b0;
            r.status = ST_TIMEOUT;
            return r;
        end
        md = (mindt != 0) ? longint'(mindt) : 1;
        dt = (gap < md) ? md : gap;
        last_t = s.t;
        ek = sp - fb;
        delta = dof ? last_fb - fb : ek - last_err;
        m = mul_div_cap(mag(delta), td * 15625, 64'(dt) * 1024, 64'(P_CAP));
        d = (delta < 0) ? -longint'(m) : longint'(m);
        p = ek + d;
        if (p > P_CAP) p = P_CAP;
        if (p < -P_CAP) p = -P_CAP;
        inc = ek * dt;
        if (inc > 0 && acc > ACC_MAX - inc) acc = ACC_MAX;
        else if (inc < 0 && acc < ACC_MIN - inc) acc = ACC_MIN;
        else acc = acc + inc;
        if (ti > 0) begin
            m = mul_div_cap(mag(acc), mag(kp) * 8, ti * 1000000, ilim + 1);
            clamped = m > ilim;
            if (clamped) m = ilim;
            integ = ((acc < 0) != (kp < 0)) ? -longint'(m) : longint'(m);
            if (kp <= 0) begin
                acc = 0;
            end else if (clamped) begin
                rr = mul_div_cap(ilim, ti * 1000000, 64'(kp) * 8, 64'(ACC_MAX));
                acc = (acc < 0) ? -longint'(rr) : longint'(rr);
            end
        end
        tau = kp * p + (integ + ff) * 8192;
        tau = tau / 8192;
        if (tau > 32767) tau = 32767;
        if (tau < -32767) tau = -32767;
        last_fb = fb;
        last_err = ek;
        r.drive = 16'(tau);
        r.status = ST_NORMAL;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) drive_expect_q.push_back(pid_predict(cur));
            if (!i_in_valid || !o_in_stall) begin
                if (samples_q.size() > 0 && !(gaps_on && $urandom_range(99) < 15)) begin
                    cur = samples_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_sample_time_us <= cur.t;
                    i_setpoint <= cur.sp;
                    i_feedback <= cur.fb;
                    i_restart <= cur.rst;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 3000;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        ctl_out_t x;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (drive_expect_q.size() == 0) begin
                    $error("unexpected output item drive=%0d status=%0d", o_drive, o_status);
                    err_count++;
                end else begin
                    x = drive_expect_q.pop_front();
                    if (o_drive !== x.drive) begin
                        $error("drive expected %0d actual %0d", x.drive, o_drive);
                        err_count++;
                    end
                    if (o_status !== x.status) begin
                        $error("status expected %0d actual %0d", x.status, o_status);
                        err_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= gaps_on && ($urandom_range(99) < 15);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_PROP_GAIN:   kp = longint'($signed(val));
            CFG_INT_TIME:    ti = 64'(val);
            CFG_DER_TIME:    td = 64'(val);
            CFG_INT_LIMIT:   ilim = 64'(val[15:0]);
            CFG_FEEDFORWARD: ff = longint'($signed(val[15:0]));
            CFG_DER_ON_FB:   dof = val[0];
            CFG_TIMEOUT:     tmo = 64'(val[23:0]);
            CFG_MIN_DT:      mindt = 64'(val[23:0]);
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] g, logic [31:0] it, logic [31:0] dtm,
                           logic [31:0] lim, logic [31:0] f, logic [31:0] onfb,
                           logic [31:0] to, logic [31:0] mn);
        write_reg(CFG_PROP_GAIN, g);
        write_reg(CFG_INT_TIME, it);
        write_reg(CFG_DER_TIME, dtm);
        write_reg(CFG_INT_LIMIT, lim);
        write_reg(CFG_FEEDFORWARD, f);
        write_reg(CFG_DER_ON_FB, onfb);
        write_reg(CFG_TIMEOUT, to);
        write_reg(CFG_MIN_DT, mn);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add(logic [31:0] gap, logic [15:0] sp, logic [15:0] fb, logic rst);
        sample_t s;
        next_t = next_t + gap;
        s.t = next_t;
        s.sp = sp;
        s.fb = fb;
        s.rst = rst;
        samples_q.push_back(s);
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (samples_q.size() > 0 || i_in_valid || drive_expect_q.size() > 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic random_items(int n);
        int          k;
        logic [31:0] gap;
        logic [15:0] sp, fb;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(99);
            if (k < 5) gap = tmo[31:0] + 1 + $urandom_range(1000);
            else if (k < 10) gap = -$urandom_range(1000000);
            else if (k < 13) gap = $urandom;
            else if (k < 40) gap = $urandom_range(mindt[31:0]);
            else gap = $urandom_range(tmo[31:0]);
            if ($urandom_range(99) < 30) begin
                sp = 16'($urandom);
                fb = 16'($urandom);
            end else begin
                sp = 16'($urandom_range(16384) - 8192);
                fb = sp + 16'($urandom_range(4000)) - 16'd2000;
            end
            add(gap, sp, fb, $urandom_range(99) < 3);
        end
    endtask

    initial begin
        logic [31:0] g, it, dtm, lim, to, mn;
        kp = 0; ti = 0; td = 0; ilim = 0; ff = 0; dof = 1'b1;
        tmo = 200000; mindt = 10000;
        primed = 1'b0; last_t = '0; last_fb = 0; last_err = 0; acc = 0;
        next_t = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration first
        add(0, 16'sd100, 16'sd0, 1'b0);
        add(5000, 16'sd4096, 16'sd1000, 1'b0);
        drain();

        set_all(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 16384, 0, 1, 200000, 10000);
        add(0, 16'h7fff, 16'h8000, 1'b0);
        add(20000, 16'h7fff, 16'h8000, 1'b0);
        add(20000, 16'h8000, 16'h7fff, 1'b0);
        add(1, 16'h0000, 16'h0000, 1'b0);
        add(-32'd500, 16'h1000, 16'h0800, 1'b0);
        add(200000, 16'h1000, 16'h0000, 1'b0);
        add(200001, 16'h1000, 16'h0000, 1'b0);
        add(10000, 16'h0123, 16'h0000, 1'b0);
        add(10000, 16'h0800, 16'hf000, 1'b0);
        add(0, 16'h0800, 16'hf000, 1'b1);
        add(10000, 16'h0800, 16'h0000, 1'b0);
        add(10000, 16'hffff, 16'h0001, 1'b0);
        add(-32'h7fffffff, 16'h0000, 16'h0000, 1'b0);
        add(32'h7fffffff, 16'h0000, 16'h0000, 1'b0);
        drain();

        // timestamps across the 32-bit wrap
        next_t = 32'hffff_ff00;
        add(0, 16'h0400, 16'h0000, 1'b0);
        add(32'h200, 16'h0400, 16'h0100, 1'b0);
        drain();

        set_all(32'h7fff_ffff, 1, 32'hffff_ffff, 65535, 32'h7fff, 1, 24'hffffff, 1);
        random_items(60);
        drain();
        set_all(32'h8000_0000, 32'hffff_ffff, 0, 0, 32'h8000, 0, 1, 24'hffffff);
        random_items(60);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(4))
                0: g = 0;
                1: g = $urandom;
                2: g = -$urandom_range(32'h40000);
                default: g = $urandom_range(32'h40000);
            endcase
            case ($urandom_range(3))
                0: it = 0;
                1: it = $urandom;
                default: it = $urandom_range(1, 32'h40000);
            endcase
            dtm = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h20000);
            lim = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535);
            to = ($urandom_range(4) == 0) ? $urandom_range(1, 24'hffffff)
                                          : $urandom_range(10000, 500000);
            mn = ($urandom_range(4) == 0) ? $urandom_range(1, 24'hffffff)
                                          : $urandom_range(1, 50000);
            set_all(g, it, dtm, lim, $urandom, $urandom_range(1), to, mn);
            gaps_on = (ph != 3);
            if (ph == 6) hold_req++;
            random_items(130);
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end

endmodule

// ----- pid_antiwindup_controller.f -----
rtl/pidaw_pkg.sv
rtl/pidaw_muldiv.sv
rtl/pid_antiwindup_controller.sv
tb/testbench.sv
